>>> rtl/dmc_pkg.sv
// dmc_pkg: shared types, constants and control-word layout for the maze carver
// used by dmc_sequencer, dmc_datapath and dfs_maze_carver_top; no dependencies

package dmc_pkg;

   // grid and stack geometry
   localparam int MAX_DIM     = 64;
   localparam int STACK_DEPTH = 1024;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int CELL_W      = 2 * DIM_W;
   localparam int CELLS       = MAX_DIM * MAX_DIM;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int SIDX_W      = $clog2(STACK_DEPTH);

   // largest odd size that still fits below MAX_DIM
   localparam int LIM_RAW   = MAX_DIM - 1;
   localparam int SIZE_LIM  = ((LIM_RAW % 2) == 0) ? LIM_RAW - 1 : LIM_RAW;

   // field widths fixed by the interface
   localparam int RW_W      = 15;
   localparam int KIND_W    = 2;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 1;
   localparam int PC_W      = 4;

   localparam logic [CFG_W-1:0] CFG_RESET = 6'd21;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'b1;

   // operation codes
   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_STEP    = 1'b1;

   // event kinds
   localparam logic [KIND_W-1:0] EV_CARVED    = 2'd0;
   localparam logic [KIND_W-1:0] EV_POPPED    = 2'd1;
   localparam logic [KIND_W-1:0] EV_FINISHED  = 2'd2;
   localparam logic [KIND_W-1:0] EV_RESTARTED = 2'd3;

   // probe directions, in search order
   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST  = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_WEST  = 2'd3;

   typedef logic [DIM_W-1:0]  dim_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [SP_W-1:0]   sp_type;
   typedef logic [PC_W-1:0]   pc_type;

   typedef struct packed {
      logic            operation;
      logic [RW_W-1:0] random_word;
   } req_payload_type;

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      dim_type           wall_row;
      dim_type           wall_col;
      dim_type           cell_row;
      dim_type           cell_col;
      logic              reached_exit;
      sp_type            depth;
   } rsp_payload_type;

   // datapath micro-operations
   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_LATCH,
      UOP_CHOOSE,
      UOP_WR_WALL,
      UOP_CARVE,
      UOP_CLEAR,
      UOP_RESTART,
      UOP_POP,
      UOP_POP_EMIT
   } uop_type;

   // sequencer jump conditions
   typedef enum logic [2:0] {
      JC_NEXT,
      JC_GOTO,
      JC_DISPATCH,
      JC_LOOP_CLR,
      JC_NO_CARVE
   } jcond_type;

   typedef struct packed {
      logic      wait_req;
      logic      rd_en;
      logic [1:0] rd_dir;
      logic      cap_en;
      logic [1:0] cap_dir;
      uop_type   uop;
      logic      emit;
      jcond_type jcond;
      pc_type    target;
   } ctrl_word_type;

   typedef struct packed {
      logic          fire;
      ctrl_word_type word;
   } step_ctrl_type;

   typedef struct packed {
      logic req_restart;
      logic sp_zero;
      logic carve_ok;
      logic clr_last;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/dfs_maze_carver_top.sv
// Maze carver: a carving or a backtracking step runs the four-direction probe over the two-read
// grid mark memory and the rest of its microcode program, offers its result and only then returns
// to accept the next transaction; a step on an empty stack skips the probe and goes straight to
// its result step; a stalled result holds off the next accept.
// A restart sweeps all 4096 grid entries, one a cycle, before it offers its result.
// Reset (synchronous) clears the step counter, stack pointer and output valid, sizes return to 21.

module dfs_maze_carver_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [dmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dmc_pkg::CFG_W-1:0]     csr_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dmc_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dmc_pkg::rsp_payload_type      rsp_payload
);

   dmc_pkg::step_ctrl_type step;
   dmc_pkg::dp_status_type status;

   // microcode sequencer
   dmc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .step      (step)
   );

   // grid, stack and result datapath
   dmc_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_payload  (req_payload),
      .step         (step),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_payload  (rsp_payload),
      .status       (status)
   );

   // a new transaction is taken only at the dispatch step
   assign req_stall = !step.word.wait_req;

endmodule

>>> rtl/dmc_sequencer.sv
// dmc_sequencer: step counter, microcode table and conditional jumps
// depends on dmc_pkg for the control word and status types

module dmc_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  dmc_pkg::dp_status_type status,
   output dmc_pkg::step_ctrl_type step
);

   // program addresses
   localparam dmc_pkg::pc_type PC_IDLE      = 4'd0;
   localparam dmc_pkg::pc_type PC_PROBE_N   = 4'd1;
   localparam dmc_pkg::pc_type PC_PROBE_E   = 4'd2;
   localparam dmc_pkg::pc_type PC_PROBE_S   = 4'd3;
   localparam dmc_pkg::pc_type PC_PROBE_W   = 4'd4;
   localparam dmc_pkg::pc_type PC_LAST_CAP  = 4'd5;
   localparam dmc_pkg::pc_type PC_CHOOSE    = 4'd6;
   localparam dmc_pkg::pc_type PC_OPEN_WALL = 4'd7;
   localparam dmc_pkg::pc_type PC_CARVE     = 4'd8;
   localparam dmc_pkg::pc_type PC_CLEAR     = 4'd9;
   localparam dmc_pkg::pc_type PC_RESTART   = 4'd10;
   localparam dmc_pkg::pc_type PC_POP       = 4'd11;
   localparam dmc_pkg::pc_type PC_POP_EMIT  = 4'd12;

   dmc_pkg::pc_type        pc_ff;
   dmc_pkg::pc_type        pc_in;
   dmc_pkg::ctrl_word_type word;
   logic                   fire;

   // microcode table
   function automatic dmc_pkg::ctrl_word_type ucode_word(input dmc_pkg::pc_type pc);
      dmc_pkg::ctrl_word_type w;
      w        = '0;
      w.uop    = dmc_pkg::UOP_NONE;
      w.jcond  = dmc_pkg::JC_NEXT;
      w.target = PC_IDLE;
      unique case (pc)
         PC_IDLE: begin
            w.wait_req = 1'b1;
            w.uop      = dmc_pkg::UOP_LATCH;
            w.jcond    = dmc_pkg::JC_DISPATCH;
         end
         PC_PROBE_N: begin
            w.rd_en  = 1'b1;
            w.rd_dir = dmc_pkg::DIR_NORTH;
         end
         PC_PROBE_E: begin
            w.rd_en   = 1'b1;
            w.rd_dir  = dmc_pkg::DIR_EAST;
            w.cap_en  = 1'b1;
            w.cap_dir = dmc_pkg::DIR_NORTH;
         end
         PC_PROBE_S: begin
            w.rd_en   = 1'b1;
            w.rd_dir  = dmc_pkg::DIR_SOUTH;
            w.cap_en  = 1'b1;
            w.cap_dir = dmc_pkg::DIR_EAST;
         end
         PC_PROBE_W: begin
            w.rd_en   = 1'b1;
            w.rd_dir  = dmc_pkg::DIR_WEST;
            w.cap_en  = 1'b1;
            w.cap_dir = dmc_pkg::DIR_SOUTH;
         end
         PC_LAST_CAP: begin
            w.cap_en  = 1'b1;
            w.cap_dir = dmc_pkg::DIR_WEST;
         end
         PC_CHOOSE: begin
            w.uop    = dmc_pkg::UOP_CHOOSE;
            w.jcond  = dmc_pkg::JC_NO_CARVE;
            w.target = PC_POP;
         end
         PC_OPEN_WALL: begin
            w.uop = dmc_pkg::UOP_WR_WALL;
         end
         PC_CARVE: begin
            w.uop    = dmc_pkg::UOP_CARVE;
            w.emit   = 1'b1;
            w.jcond  = dmc_pkg::JC_GOTO;
            w.target = PC_IDLE;
         end
         PC_CLEAR: begin
            w.uop    = dmc_pkg::UOP_CLEAR;
            w.jcond  = dmc_pkg::JC_LOOP_CLR;
            w.target = PC_CLEAR;
         end
         PC_RESTART: begin
            w.uop    = dmc_pkg::UOP_RESTART;
            w.emit   = 1'b1;
            w.jcond  = dmc_pkg::JC_GOTO;
            w.target = PC_IDLE;
         end
         PC_POP: begin
            w.uop = dmc_pkg::UOP_POP;
         end
         PC_POP_EMIT: begin
            w.uop    = dmc_pkg::UOP_POP_EMIT;
            w.emit   = 1'b1;
            w.jcond  = dmc_pkg::JC_GOTO;
            w.target = PC_IDLE;
         end
         default: begin
            w.jcond  = dmc_pkg::JC_GOTO;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

   // a step fires on a new transaction, on room in the output register, or at once
   always_comb begin
      word = ucode_word(pc_ff);
      if (word.wait_req) begin
         fire = req_valid;
      end else if (word.emit) begin
         fire = status.out_free;
      end else begin
         fire = 1'b1;
      end
   end

   // next step address
   always_comb begin
      pc_in = pc_ff;
      if (fire) begin
         unique case (word.jcond)
            dmc_pkg::JC_NEXT: pc_in = pc_ff + 1'b1;
            dmc_pkg::JC_GOTO: pc_in = word.target;
            dmc_pkg::JC_DISPATCH: begin
               if (status.req_restart) begin
                  pc_in = PC_CLEAR;
               end else if (status.sp_zero) begin
                  pc_in = PC_POP_EMIT;
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
            dmc_pkg::JC_LOOP_CLR: pc_in = status.clr_last ? pc_ff + 1'b1 : word.target;
            dmc_pkg::JC_NO_CARVE: pc_in = status.carve_ok ? pc_ff + 1'b1 : word.target;
            default: pc_in = PC_IDLE;
         endcase
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign step.fire = fire;
   assign step.word = word;

endmodule

>>> rtl/dmc_datapath.sv
// dmc_datapath: grid mark memory, cell stack, geometry, direction choice and result register
// depends on dmc_pkg; driven by the control word from dmc_sequencer

module dmc_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [dmc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dmc_pkg::CFG_W-1:0]             csr_data,
   input  dmc_pkg::req_payload_type              req_payload,
   input  dmc_pkg::step_ctrl_type                step,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output dmc_pkg::rsp_payload_type              rsp_payload,
   output dmc_pkg::dp_status_type                status
);

   localparam int DW = dmc_pkg::DIM_W;
   localparam int CW = dmc_pkg::CELL_W;
   localparam int SW = dmc_pkg::SP_W;
   localparam logic [DW:0] MAX_X = (DW + 1)'(dmc_pkg::MAX_DIM);
   localparam dmc_pkg::cell_type START_CELL = {DW'(1), DW'(1)};

   typedef struct packed {
      logic              ok;
      dmc_pkg::cell_type wall;
      dmc_pkg::cell_type room;
   } nbr_type;

   // mark memory: on a wall cell it means opened, on a room cell visited
   logic mark_mem [dmc_pkg::CELLS];
   dmc_pkg::cell_type stack_mem [dmc_pkg::STACK_DEPTH];

   logic [dmc_pkg::CFG_W-1:0] cfg_rows_ff, cfg_cols_ff;
   dmc_pkg::dim_type          eff_rows_ff, eff_cols_ff;
   dmc_pkg::sp_type           sp_ff;
   logic                      exit_seen_ff;
   logic                      rsp_valid_ff;
   dmc_pkg::rsp_payload_type  rsp_payload_ff;
   logic [dmc_pkg::RW_W-2:0]  rw_ff;
   dmc_pkg::cell_type         top_ff;
   dmc_pkg::cell_type         clr_cnt_ff;
   dmc_pkg::cell_type         wall_cell_ff, room_cell_ff;
   dmc_pkg::cell_type         stack_rd_ff;
   logic                      wall_mark_ff, room_mark_ff, geo_ok_ff;
   logic [3:0]                cand_ff;

   nbr_type                  probe, pick;
   logic [2:0]               n_cand;
   logic [1:0]               k_sel, sel_dir;
   logic [2:0]               seen_cnt;
   logic                     found;
   logic                     emit_fire;
   logic                     reached_now;
   dmc_pkg::rsp_payload_type rsp_next;
   logic                     mark_we, mark_wdata;
   dmc_pkg::cell_type        mark_waddr;
   logic                     stack_we, stack_re;
   logic [dmc_pkg::SIDX_W-1:0] stack_waddr, stack_raddr;
   dmc_pkg::cell_type        stack_wdata;
   dmc_pkg::sp_type          sp_dec2;

   // size rounding: odd, at least three, at most the limit
   function automatic dmc_pkg::dim_type eff_size(input logic [dmc_pkg::CFG_W-1:0] cfg);
      int v;
      v = int'(cfg) | 1;
      if (v < 3) v = 3;
      if (v > dmc_pkg::SIZE_LIM) v = dmc_pkg::SIZE_LIM;
      return DW'(v);
   endfunction

   // wall one cell and room two cells away in one direction, and whether the move is in bounds
   function automatic nbr_type neighbour(input dmc_pkg::cell_type top, input logic [1:0] dir,
                                         input dmc_pkg::dim_type rows,
                                         input dmc_pkg::dim_type cols);
      dmc_pkg::dim_type r, c;
      logic [DW:0]      r_x, c_x;
      nbr_type          n;
      r   = top[CW-1:DW];
      c   = top[DW-1:0];
      r_x = {1'b0, r};
      c_x = {1'b0, c};
      n   = '0;
      case (dir)
         dmc_pkg::DIR_NORTH: begin
            n.wall = {r - DW'(1), c};
            n.room = {r - DW'(2), c};
            n.ok   = (r != DW'(1)) && (r >= DW'(2));
         end
         dmc_pkg::DIR_EAST: begin
            n.wall = {r, c + DW'(1)};
            n.room = {r, c + DW'(2)};
            n.ok   = (c != cols - DW'(2)) && ((c_x + (DW + 1)'(2)) < MAX_X);
         end
         dmc_pkg::DIR_SOUTH: begin
            n.wall = {r + DW'(1), c};
            n.room = {r + DW'(2), c};
            n.ok   = (r != rows - DW'(2)) && ((r_x + (DW + 1)'(2)) < MAX_X);
         end
         default: begin
            n.wall = {r, c - DW'(1)};
            n.room = {r, c - DW'(2)};
            n.ok   = (c != DW'(1)) && (c >= DW'(2));
         end
      endcase
      return n;
   endfunction

   // residue mod 3 via base-4 digit sums
   function automatic logic [1:0] mod3(input logic [dmc_pkg::RW_W-2:0] x);
      logic [4:0] s;
      logic [2:0] t;
      logic [1:0] m;
      s = '0;
      for (int i = 0; i < dmc_pkg::RW_W - 1; i += 2) begin
         s = s + 5'(x[i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      case (t)
         3'd0, 3'd3, 3'd6: m = 2'd0;
         3'd1, 3'd4, 3'd7: m = 2'd1;
         default:          m = 2'd2;
      endcase
      return m;
   endfunction

   // probe address for the read steps
   assign probe = neighbour(top_ff, step.word.rd_dir, eff_rows_ff, eff_cols_ff);

   // candidate count and random pick of the k-th open direction
   always_comb begin
      n_cand = 3'($countones(cand_ff));
      case (n_cand)
         3'd2:    k_sel = {1'b0, rw_ff[0]};
         3'd3:    k_sel = mod3(rw_ff);
         3'd4:    k_sel = rw_ff[1:0];
         default: k_sel = 2'd0;
      endcase
      seen_cnt = '0;
      found    = 1'b0;
      sel_dir  = dmc_pkg::DIR_NORTH;
      for (int d = 0; d < 4; d++) begin
         if (cand_ff[d]) begin
            if (!found && seen_cnt == {1'b0, k_sel}) begin
               sel_dir = 2'(d);
               found   = 1'b1;
            end
            seen_cnt = seen_cnt + 3'd1;
         end
      end
   end

   assign pick = neighbour(top_ff, sel_dir, eff_rows_ff, eff_cols_ff);

   // status back to the sequencer
   assign status.req_restart = (req_payload.operation == dmc_pkg::OP_RESTART);
   assign status.sp_zero     = (sp_ff == '0);
   assign status.carve_ok    = (n_cand != 3'd0) && (sp_ff < SW'(dmc_pkg::STACK_DEPTH));
   assign status.clr_last    = (clr_cnt_ff == CW'(dmc_pkg::CELLS - 1));
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   assign emit_fire   = step.fire && step.word.emit;
   assign reached_now = !exit_seen_ff &&
                        (room_cell_ff == {eff_rows_ff - DW'(2), eff_cols_ff - DW'(2)});
   assign sp_dec2     = sp_ff - SW'(2);

   // mark memory write port
   always_comb begin
      mark_we    = 1'b0;
      mark_waddr = clr_cnt_ff;
      mark_wdata = 1'b0;
      if (step.fire) begin
         case (step.word.uop)
            dmc_pkg::UOP_CLEAR: begin
               mark_we = 1'b1;
            end
            dmc_pkg::UOP_WR_WALL: begin
               mark_we    = 1'b1;
               mark_waddr = wall_cell_ff;
               mark_wdata = 1'b1;
            end
            dmc_pkg::UOP_CARVE: begin
               mark_we    = 1'b1;
               mark_waddr = room_cell_ff;
               mark_wdata = 1'b1;
            end
            dmc_pkg::UOP_RESTART: begin
               mark_we    = 1'b1;
               mark_waddr = START_CELL;
               mark_wdata = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // stack ports: push on carve and restart, read the new top on pop
   always_comb begin
      stack_we    = step.fire && ((step.word.uop == dmc_pkg::UOP_CARVE) ||
                                  (step.word.uop == dmc_pkg::UOP_RESTART));
      stack_waddr = (step.word.uop == dmc_pkg::UOP_CARVE) ? sp_ff[dmc_pkg::SIDX_W-1:0] : '0;
      stack_wdata = (step.word.uop == dmc_pkg::UOP_CARVE) ? room_cell_ff : START_CELL;
      stack_re    = step.fire && (step.word.uop == dmc_pkg::UOP_POP);
      stack_raddr = sp_dec2[dmc_pkg::SIDX_W-1:0];
   end

   // next result transaction
   always_comb begin
      rsp_next = '0;
      case (step.word.uop)
         dmc_pkg::UOP_CARVE: begin
            rsp_next.event_kind   = dmc_pkg::EV_CARVED;
            rsp_next.wall_row     = wall_cell_ff[CW-1:DW];
            rsp_next.wall_col     = wall_cell_ff[DW-1:0];
            rsp_next.cell_row     = room_cell_ff[CW-1:DW];
            rsp_next.cell_col     = room_cell_ff[DW-1:0];
            rsp_next.reached_exit = reached_now;
            rsp_next.depth        = sp_ff + 1'b1;
         end
         dmc_pkg::UOP_RESTART: begin
            rsp_next.event_kind = dmc_pkg::EV_RESTARTED;
            rsp_next.cell_row   = START_CELL[CW-1:DW];
            rsp_next.cell_col   = START_CELL[DW-1:0];
            rsp_next.depth      = SW'(1);
         end
         dmc_pkg::UOP_POP_EMIT: begin
            if (sp_ff == '0) begin
               rsp_next.event_kind = dmc_pkg::EV_FINISHED;
            end else begin
               rsp_next.event_kind = dmc_pkg::EV_POPPED;
               rsp_next.cell_row   = stack_rd_ff[CW-1:DW];
               rsp_next.cell_col   = stack_rd_ff[DW-1:0];
               rsp_next.depth      = sp_ff;
            end
         end
         default: ;
      endcase
   end

   // mark memory, two registered reads for one probe direction
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_waddr] <= mark_wdata;
      end
      if (step.word.rd_en) begin
         wall_mark_ff <= mark_mem[probe.wall];
         room_mark_ff <= mark_mem[probe.room];
      end
   end

   // cell stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   // control state: configuration, sizes, stack pointer, exit flag, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_rows_ff  <= dmc_pkg::CFG_RESET;
         cfg_cols_ff  <= dmc_pkg::CFG_RESET;
         eff_rows_ff  <= eff_size(dmc_pkg::CFG_RESET);
         eff_cols_ff  <= eff_size(dmc_pkg::CFG_RESET);
         sp_ff        <= '0;
         exit_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               dmc_pkg::CSR_GRID_ROWS: cfg_rows_ff <= csr_data;
               dmc_pkg::CSR_GRID_COLS: cfg_cols_ff <= csr_data;
               default: ;
            endcase
         end
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (step.fire) begin
            case (step.word.uop)
               dmc_pkg::UOP_LATCH: begin
                  if (status.req_restart) begin
                     eff_rows_ff <= eff_size(cfg_rows_ff);
                     eff_cols_ff <= eff_size(cfg_cols_ff);
                  end
               end
               dmc_pkg::UOP_CARVE: begin
                  sp_ff <= sp_ff + 1'b1;
                  if (reached_now) begin
                     exit_seen_ff <= 1'b1;
                  end
               end
               dmc_pkg::UOP_RESTART: begin
                  sp_ff        <= SW'(1);
                  exit_seen_ff <= 1'b0;
               end
               dmc_pkg::UOP_POP: begin
                  sp_ff <= sp_ff - 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (step.word.rd_en) begin
         geo_ok_ff <= probe.ok;
      end
      if (step.word.cap_en) begin
         cand_ff[step.word.cap_dir] <= geo_ok_ff && !wall_mark_ff && !room_mark_ff;
      end
      if (step.fire) begin
         case (step.word.uop)
            dmc_pkg::UOP_LATCH: begin
               rw_ff      <= req_payload.random_word[dmc_pkg::RW_W-1:1];
               clr_cnt_ff <= '0;
            end
            dmc_pkg::UOP_CHOOSE: begin
               wall_cell_ff <= pick.wall;
               room_cell_ff <= pick.room;
            end
            dmc_pkg::UOP_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + 1'b1;
            end
            dmc_pkg::UOP_CARVE: begin
               top_ff <= room_cell_ff;
            end
            dmc_pkg::UOP_RESTART: begin
               top_ff <= START_CELL;
            end
            dmc_pkg::UOP_POP_EMIT: begin
               if (sp_ff != '0) begin
                  top_ff <= stack_rd_ff;
               end
            end
            default: ;
         endcase
      end
      if (emit_fire) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> bench/tb_dfs_maze_carver_top.sv
// tb_dfs_maze_carver_top: self-checking bench for the maze carver, predicting each event
// from its own copy of the grid marks, the room stack and the size registers
// depends on dmc_pkg and dfs_maze_carver_top

module tb_dfs_maze_carver_top;

   localparam int COMMAND_TARGET = 950;
   localparam int QUIET_TAIL     = 100;
   localparam int WATCHDOG_LIMIT = 20000;

   // grid model, room stack and expected events
   class maze_scoreboard;
      bit                       open_map [dmc_pkg::CELLS];
      bit                       visited_map [dmc_pkg::CELLS];
      int unsigned              room_stack [dmc_pkg::STACK_DEPTH];
      int unsigned              stack_depth;
      bit                       exit_seen;
      int unsigned              rows_reg;
      int unsigned              cols_reg;
      int unsigned              eff_rows;
      int unsigned              eff_cols;
      int unsigned              cand_wr [4];
      int unsigned              cand_wc [4];
      int unsigned              cand_cr [4];
      int unsigned              cand_cc [4];
      int unsigned              cand_count;
      dmc_pkg::rsp_payload_type expected_events [$];
      int                       mismatches;

      function new();
         foreach (open_map[i]) begin
            open_map[i]    = 1'b0;
            visited_map[i] = 1'b0;
         end
         stack_depth = 0;
         exit_seen   = 1'b0;
         rows_reg    = dmc_pkg::CFG_RESET;
         cols_reg    = dmc_pkg::CFG_RESET;
         eff_rows    = fit_size(dmc_pkg::CFG_RESET);
         eff_cols    = fit_size(dmc_pkg::CFG_RESET);
         mismatches  = 0;
      endfunction

      // sizes round up to odd and clamp to 3 .. largest odd below the grid limit
      function int unsigned fit_size(int unsigned v);
         int unsigned s;
         s = v | 1;
         if (s < 3) s = 3;
         if (s > dmc_pkg::SIZE_LIM) s = dmc_pkg::SIZE_LIM;
         return s;
      endfunction

      function int unsigned cell_at(int unsigned r, int unsigned c);
         return (r * dmc_pkg::MAX_DIM + c) % dmc_pkg::CELLS;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      function void note_register(logic [dmc_pkg::CSR_IDX_W-1:0] idx,
                                  logic [dmc_pkg::CFG_W-1:0] value);
         if (idx == dmc_pkg::CSR_GRID_ROWS) rows_reg = value;
         else rows_reg = rows_reg;
         if (idx == dmc_pkg::CSR_GRID_COLS) cols_reg = value;
      endfunction

      // rebuild the walls, open entry and exit gaps, seed the stack with room (1,1)
      function void clear_grid();
         eff_rows = fit_size(rows_reg);
         eff_cols = fit_size(cols_reg);
         foreach (open_map[i]) begin
            open_map[i]    = 1'b0;
            visited_map[i] = 1'b0;
         end
         for (int unsigned r = 0; r < eff_rows; r++) begin
            for (int unsigned c = 0; c < eff_cols; c++) begin
               if (r % 2 == 1 && c % 2 == 1 && r != eff_rows - 1 && c != eff_cols - 1)
                  open_map[cell_at(r, c)] = 1'b1;
            end
         end
         open_map[cell_at(1, 0)]                       = 1'b1;
         open_map[cell_at(eff_rows - 2, eff_cols - 1)] = 1'b1;
         visited_map[cell_at(1, 1)]                    = 1'b1;
         room_stack[0] = cell_at(1, 1);
         stack_depth   = 1;
         exit_seen     = 1'b0;
      endfunction

      function void add_route(int unsigned wr, int unsigned wc, int unsigned cr,
                              int unsigned cc);
         cand_wr[cand_count] = wr;
         cand_wc[cand_count] = wc;
         cand_cr[cand_count] = cr;
         cand_cc[cand_count] = cc;
         cand_count++;
      endfunction

      // work out the event caused by one accepted command
      function void note_command(dmc_pkg::req_payload_type cmd);
         dmc_pkg::rsp_payload_type ev;
         int unsigned              top, r, c, k, word;
         ev = '0;
         if (cmd.operation == dmc_pkg::OP_RESTART) begin
            clear_grid();
            ev.event_kind = dmc_pkg::EV_RESTARTED;
            ev.cell_row   = dmc_pkg::dim_type'(1);
            ev.cell_col   = dmc_pkg::dim_type'(1);
            ev.depth      = dmc_pkg::sp_type'(stack_depth);
         end else if (stack_depth == 0) begin
            ev.event_kind = dmc_pkg::EV_FINISHED;
         end else begin
            top        = room_stack[(stack_depth - 1) % dmc_pkg::STACK_DEPTH];
            r          = top / dmc_pkg::MAX_DIM;
            c          = top % dmc_pkg::MAX_DIM;
            cand_count = 0;
            // probe north, east, south, west for closed walls to unvisited rooms
            if (r != 1 && r >= 2 && !open_map[cell_at(r - 1, c)]
                && !visited_map[cell_at(r - 2, c)])
               add_route(r - 1, c, r - 2, c);
            if (c != eff_cols - 2 && c + 2 < dmc_pkg::MAX_DIM && !open_map[cell_at(r, c + 1)]
                && !visited_map[cell_at(r, c + 2)])
               add_route(r, c + 1, r, c + 2);
            if (r != eff_rows - 2 && r + 2 < dmc_pkg::MAX_DIM && !open_map[cell_at(r + 1, c)]
                && !visited_map[cell_at(r + 2, c)])
               add_route(r + 1, c, r + 2, c);
            if (c != 1 && c >= 2 && !open_map[cell_at(r, c - 1)]
                && !visited_map[cell_at(r, c - 2)])
               add_route(r, c - 1, r, c - 2);
            if (cand_count > 0 && stack_depth < dmc_pkg::STACK_DEPTH) begin
               // carve through the chosen wall
               word = cmd.random_word;
               k    = (word % (2 * cand_count)) / 2;
               open_map[cell_at(cand_wr[k], cand_wc[k])]    = 1'b1;
               visited_map[cell_at(cand_cr[k], cand_cc[k])] = 1'b1;
               room_stack[stack_depth] = cell_at(cand_cr[k], cand_cc[k]);
               stack_depth++;
               ev.event_kind = dmc_pkg::EV_CARVED;
               ev.wall_row   = dmc_pkg::dim_type'(cand_wr[k]);
               ev.wall_col   = dmc_pkg::dim_type'(cand_wc[k]);
               ev.cell_row   = dmc_pkg::dim_type'(cand_cr[k]);
               ev.cell_col   = dmc_pkg::dim_type'(cand_cc[k]);
               if (!exit_seen && cand_cr[k] == eff_rows - 2 && cand_cc[k] == eff_cols - 2) begin
                  exit_seen       = 1'b1;
                  ev.reached_exit = 1'b1;
               end
            end else begin
               // backtrack; emptying the stack counts as finished
               stack_depth--;
               if (stack_depth == 0) begin
                  ev.event_kind = dmc_pkg::EV_FINISHED;
               end else begin
                  top           = room_stack[(stack_depth - 1) % dmc_pkg::STACK_DEPTH];
                  ev.event_kind = dmc_pkg::EV_POPPED;
                  ev.cell_row   = dmc_pkg::dim_type'(top / dmc_pkg::MAX_DIM);
                  ev.cell_col   = dmc_pkg::dim_type'(top % dmc_pkg::MAX_DIM);
               end
            end
            ev.depth = dmc_pkg::sp_type'(stack_depth);
         end
         expected_events.push_back(ev);
      endfunction

      task report(string msg);
         $display("%0t: %s", $time, msg);
         mismatches++;
      endtask

      // compare one accepted event with the oldest prediction
      task check_event(dmc_pkg::rsp_payload_type got);
         dmc_pkg::rsp_payload_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("event with none outstanding, kind %0d", got.event_kind));
         end else begin
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind)
               report($sformatf("event_kind %0d, predicted %0d", got.event_kind,
                                want.event_kind));
            if (got.wall_row !== want.wall_row)
               report($sformatf("wall_row %0d, predicted %0d", got.wall_row, want.wall_row));
            if (got.wall_col !== want.wall_col)
               report($sformatf("wall_col %0d, predicted %0d", got.wall_col, want.wall_col));
            if (got.cell_row !== want.cell_row)
               report($sformatf("cell_row %0d, predicted %0d", got.cell_row, want.cell_row));
            if (got.cell_col !== want.cell_col)
               report($sformatf("cell_col %0d, predicted %0d", got.cell_col, want.cell_col));
            if (got.reached_exit !== want.reached_exit)
               report($sformatf("reached_exit %0d, predicted %0d", got.reached_exit,
                                want.reached_exit));
            if (got.depth !== want.depth)
               report($sformatf("depth %0d, predicted %0d", got.depth, want.depth));
         end
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          csr_write_en;
   logic [dmc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [dmc_pkg::CFG_W-1:0]     csr_data;
   logic                          req_valid;
   logic                          req_stall;
   dmc_pkg::req_payload_type      req_payload;
   logic                          rsp_valid;
   logic                          rsp_stall;
   dmc_pkg::rsp_payload_type      rsp_payload;

   maze_scoreboard board;
   bit             quiet;
   int             commands_sent;
   int             cycles_without_transaction;

   dfs_maze_carver_top dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // send one command; valid stays high afterwards unless a gap follows
   task automatic issue_command(input logic op, input logic [dmc_pkg::RW_W-1:0] word);
      dmc_pkg::req_payload_type cmd;
      cmd.operation   = op;
      cmd.random_word = word;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_command(cmd);
      commands_sent++;
   endtask

   task automatic restart_maze();
      issue_command(dmc_pkg::OP_RESTART, dmc_pkg::RW_W'($urandom_range(0, 32767)));
   endtask

   task automatic carve_step(input logic [dmc_pkg::RW_W-1:0] word);
      issue_command(dmc_pkg::OP_STEP, word);
   endtask

   // wait until every predicted event has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // write both size registers on consecutive edges
   task automatic program_size(input logic [dmc_pkg::CFG_W-1:0] rows,
                               input logic [dmc_pkg::CFG_W-1:0] cols);
      csr_write_en <= 1'b1;
      csr_index    <= dmc_pkg::CSR_GRID_ROWS;
      csr_data     <= rows;
      @(posedge clock);
      board.note_register(dmc_pkg::CSR_GRID_ROWS, rows);
      csr_index    <= dmc_pkg::CSR_GRID_COLS;
      csr_data     <= cols;
      @(posedge clock);
      board.note_register(dmc_pkg::CSR_GRID_COLS, cols);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // result side back-pressure in bursts, with long clear stretches
   initial begin
      int run;
      rsp_stall <= 1'b0;
      forever begin
         run = $urandom_range(1, 40);
         if ($urandom_range(0, 7) == 0) run = $urandom_range(100, 300);
         repeat (run) @(posedge clock);
         if (!quiet) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // event checking and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_event(rsp_payload);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            cycles_without_transaction = 0;
         else
            cycles_without_transaction++;
         if (cycles_without_transaction >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int unsigned rows, cols, rooms, steps;
      board                      = new();
      quiet                      = 1'b0;
      commands_sent              = 0;
      cycles_without_transaction = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= dmc_pkg::CSR_GRID_ROWS;
      csr_data     <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // steps on an empty stack before any restart
      carve_step(15'h7FFF);
      carve_step(15'h0000);
      // default 21 by 21 maze, direction choice extremes
      restart_maze();
      carve_step(15'h0000);
      carve_step(15'h7FFF);
      carve_step(15'h0001);
      carve_step(15'h0002);
      carve_step(15'h0003);
      carve_step(15'h5555);
      // tiny sizes written mid-maze apply only from the next restart
      settle();
      program_size(6'd0, 6'd1);
      carve_step(15'h2AAA);
      // 3 by 3: start is the far corner, the pop empties the stack
      restart_maze();
      carve_step(15'h7FFF);
      carve_step(15'h1234);
      // largest sizes
      settle();
      program_size(6'd63, 6'd63);
      restart_maze();
      carve_step(15'h4000);
      carve_step(15'h7FFF);
      carve_step(15'h0000);
      carve_step(15'h1234);
      // even sizes round up to odd
      settle();
      program_size(6'd2, 6'd62);
      restart_maze();
      carve_step(15'h0000);
      carve_step(15'h7FFF);
      carve_step(15'h3C3C);

      // random mazes: mostly small ones carved to completion
      while (commands_sent < COMMAND_TARGET) begin
         settle();
         rows = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 14);
         cols = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 14);
         program_size(dmc_pkg::CFG_W'(rows), dmc_pkg::CFG_W'(cols));
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6))
               carve_step(dmc_pkg::RW_W'($urandom_range(0, 32767)));
         end
         restart_maze();
         rooms = ((board.fit_size(rows) - 1) / 2) * ((board.fit_size(cols) - 1) / 2);
         if (rooms <= 60) steps = 2 * rooms + $urandom_range(0, 2);
         else steps = $urandom_range(20, 150);
         for (int unsigned i = 0; i < steps && commands_sent < COMMAND_TARGET; i++) begin
            quiet = (commands_sent >= COMMAND_TARGET - QUIET_TAIL);
            // occasional restart that breaks off the maze
            if ($urandom_range(0, 59) == 0) restart_maze();
            else carve_step(dmc_pkg::RW_W'($urandom_range(0, 32767)));
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> dfs_maze_carver_top.f
rtl/dmc_pkg.sv
rtl/dmc_sequencer.sv
rtl/dmc_datapath.sv
rtl/dfs_maze_carver_top.sv
bench/tb_dfs_maze_carver_top.sv
